[sv/bmp24_to_lcd_window_writer_top_assert.svh]
// Assertion macros for the window writer
`ifndef BMP24_TO_LCD_WINDOW_WRITER_TOP_ASSERT_SVH
`define BMP24_TO_LCD_WINDOW_WRITER_TOP_ASSERT_SVH
`ifndef SYNTH
`define BMPW_ASSERT_NOW(name, clk, rst_n, a, b) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define BMPW_ASSERT_NEXT(name, clk, rst_n, a, b) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define BMPW_ASSERT_NOW(name, clk, rst_n, a, b)
`define BMPW_ASSERT_NEXT(name, clk, rst_n, a, b)
`endif
`endif

[sv/bmpw_pkg.sv]
`timescale 1ns / 1ps
package bmpw_pkg;
	localparam int SCREEN_WIDTH_DEF    = 240;
	localparam int SCREEN_HEIGHT_DEF   = 320;
	localparam int MAX_IMAGE_WIDTH_DEF = 1280;

	localparam logic [5:0] HDR_LAST = 6'd33;

	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [15:0] CMD_HWIN   = 16'h0046;
	localparam logic [15:0] CMD_VEND   = 16'h0048;
	localparam logic [15:0] CMD_VSTART = 16'h0047;
	localparam logic [15:0] CMD_XADDR  = 16'h0020;
	localparam logic [15:0] CMD_YADDR  = 16'h0021;
	localparam logic [15:0] CMD_WRAM   = 16'h0022;

	localparam logic REG_COLUMN = 1'b0;
	localparam logic REG_ROW    = 1'b1;

	localparam logic [3:0] ST_WIN_LAST = 4'd10;
	localparam logic [3:0] ST_PIX      = 4'd11;
	localparam logic [3:0] ST_FIN      = 4'd12;
	localparam logic [3:0] ST_REJ      = 4'd13;

	typedef struct packed {
		logic        win;
		logic        pix;
		logic        fin;
		logic        rej;
		logic [8:0]  row;
		logic [7:0]  left;
		logic [7:0]  right;
		logic [15:0] word;
	} job_t;

	typedef struct packed {
		logic       has;
		logic [3:0] step;
	} step_t;

	function automatic step_t first_step(input job_t j);
		step_t s;
		s.has = 1'b1;
		if (j.win) s.step = 4'd0;
		else if (j.pix) s.step = ST_PIX;
		else if (j.fin) s.step = ST_FIN;
		else begin
			s.step = ST_REJ;
			s.has  = j.rej;
		end
		return s;
	endfunction

	function automatic step_t next_step(input job_t j, input logic [3:0] cur);
		step_t s;
		s.has  = 1'b0;
		s.step = cur;
		if (cur < ST_WIN_LAST) begin
			s.has  = 1'b1;
			s.step = cur + 4'd1;
		end else if (cur == ST_WIN_LAST) begin
			if (j.pix) begin
				s.has  = 1'b1;
				s.step = ST_PIX;
			end else if (j.fin) begin
				s.has  = 1'b1;
				s.step = ST_FIN;
			end
		end else if (cur == ST_PIX && j.fin) begin
			s.has  = 1'b1;
			s.step = ST_FIN;
		end
		return s;
	endfunction
endpackage

[sv/bmpw_front.sv]
`timescale 1ns / 1ps
module bmpw_front import bmpw_pkg::*; #(
	parameter int SCREEN_WIDTH    = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT   = SCREEN_HEIGHT_DEF,
	parameter int MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] b,
	input  logic       first,
	output logic       push,
	output job_t       job
);
	localparam logic [31:0] SW32 = 32'(SCREEN_WIDTH);
	localparam logic [31:0] SH32 = 32'(SCREEN_HEIGHT);
	localparam logic [31:0] MW32 = 32'(MAX_IMAGE_WIDTH);

	logic [31:0] pos_q, pds_q, w_q, h_q, skip_q;
	logic [31:0] n_pos, n_pds, n_w, n_h, n_skip;
	logic        ok_q, draw_q, n_ok, n_draw;
	logic [13:0] stride_q, bir_q, n_stride, n_bir, bir_inc;
	logic [7:0]  left_q, right_q, n_left, n_right;
	logic [8:0]  cur_q, top_q, n_cur, n_top;
	logic [1:0]  phase_q, n_phase;
	logic [15:0] part_q, n_part;
	logic [9:0]  shown_q, n_shown;
	logic        w_big, h_big, bad;
	logic [8:0]  xs9, xe9, shown9;
	logic [9:0]  ys10, ye10;
	logic [14:0] s15;

	always_comb begin
		w_big  = w_q > SW32;
		h_big  = h_q > SH32;
		xs9    = (9'(SCREEN_WIDTH) - w_q[8:0]) >> 1;
		xe9    = xs9 + w_q[8:0] - 9'd1;
		ys10   = (10'(SCREEN_HEIGHT) - h_q[9:0]) >> 1;
		ye10   = ys10 + h_q[9:0] - 10'd1;
		s15    = {1'b0, w_q[12:0], 1'b0} + {2'b0, w_q[12:0]} + 15'd3;
		shown9 = w_big ? 9'(SCREEN_WIDTH) : w_q[8:0];
		bad    = (w_q == 32'd0) || (w_q > MW32) || (h_q == 32'd0)
			|| (pds_q < 32'(HDR_LAST) + 32'd1);
		bir_inc = bir_q + 14'd1;
	end

	always_comb begin
		n_pos = pos_q; n_pds = pds_q; n_w = w_q; n_h = h_q; n_skip = skip_q;
		n_ok = ok_q; n_draw = draw_q; n_stride = stride_q; n_bir = bir_q;
		n_left = left_q; n_right = right_q; n_cur = cur_q; n_top = top_q;
		n_phase = phase_q; n_part = part_q; n_shown = shown_q;
		job = '0;
		job.row   = cur_q;
		job.left  = left_q;
		job.right = right_q;
		if (first) begin
			n_pos = 32'd1; n_pds = '0; n_w = '0; n_h = '0; n_skip = '0;
			n_ok = 1'b1; n_draw = 1'b0; n_stride = '0; n_bir = '0;
			n_left = '0; n_right = '0; n_cur = '0; n_top = '0;
			n_phase = '0; n_part = '0; n_shown = '0;
		end else begin
			n_pos = (&pos_q) ? pos_q : pos_q + 32'd1;
			if (pos_q <= 32'(HDR_LAST)) begin
				unique case (pos_q[5:0])
					6'd10: n_pds[7:0]   = b;
					6'd11: n_pds[15:8]  = b;
					6'd12: n_pds[23:16] = b;
					6'd13: n_pds[31:24] = b;
					6'd18: n_w[7:0]     = b;
					6'd19: n_w[15:8]    = b;
					6'd20: n_w[23:16]   = b;
					6'd21: n_w[31:24]   = b;
					6'd22: n_h[7:0]     = b;
					6'd23: n_h[15:8]    = b;
					6'd24: n_h[23:16]   = b;
					6'd25: n_h[31:24]   = b;
					6'd26: n_ok = ok_q && (b == 8'd1);
					6'd28: n_ok = ok_q && (b == 8'd24);
					6'd27, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33:
						n_ok = ok_q && (b == 8'd0);
					default: n_ok = ok_q;
				endcase
				if (pos_q[5:0] == HDR_LAST) begin
					if (!n_ok || bad) begin
						n_ok    = 1'b0;
						job.rej = 1'b1;
					end else begin
						n_stride = {s15[13:2], 2'b00};
						n_shown  = {shown9, 1'b0} + {1'b0, shown9};
						n_left   = w_big ? 8'd0 : xs9[7:0];
						n_right  = w_big ? 8'(SCREEN_WIDTH - 1) : xe9[7:0];
						n_top    = h_big ? 9'd0 : ys10[8:0];
						n_cur    = h_big ? 9'(SCREEN_HEIGHT - 1) : ye10[8:0];
						n_skip   = h_big ? h_q - SH32 : 32'd0;
						n_bir    = '0;
						n_phase  = '0;
						n_draw   = 1'b1;
					end
				end
			end else if (draw_q && pos_q >= pds_q) begin
				if (skip_q == 32'd0) begin
					job.win = (bir_q == 14'd0);
					unique case (phase_q)
						2'd0: begin
							n_part  = {11'd0, b[7:3]};
							n_phase = 2'd1;
						end
						2'd1: begin
							n_part  = part_q | {5'd0, b[7:2], 5'd0};
							n_phase = 2'd2;
						end
						default: begin
							job.word = part_q | {b[7:3], 11'd0};
							n_phase  = 2'd0;
							if (bir_q < {4'd0, shown_q}) begin
								job.pix = 1'b1;
								if (bir_q == {4'd0, shown_q} - 14'd1 && cur_q == top_q) begin
									job.fin = 1'b1;
									n_draw  = 1'b0;
								end
							end
						end
					endcase
				end
				if (!job.fin) begin
					n_bir = bir_inc;
					if (bir_inc >= stride_q) begin
						n_bir   = '0;
						n_phase = '0;
						if (skip_q != 32'd0) n_skip = skip_q - 32'd1;
						else if (cur_q > top_q) n_cur = cur_q - 9'd1;
					end
				end
			end
		end
		push = acc && (job.win || job.pix || job.fin || job.rej);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; pds_q <= '0; w_q <= '0; h_q <= '0; skip_q <= '0;
			ok_q <= 1'b1; draw_q <= 1'b0; stride_q <= '0; bir_q <= '0;
			left_q <= '0; right_q <= '0; cur_q <= '0; top_q <= '0;
			phase_q <= '0; part_q <= '0; shown_q <= '0;
		end else if (acc) begin
			pos_q <= n_pos; pds_q <= n_pds; w_q <= n_w; h_q <= n_h; skip_q <= n_skip;
			ok_q <= n_ok; draw_q <= n_draw; stride_q <= n_stride; bir_q <= n_bir;
			left_q <= n_left; right_q <= n_right; cur_q <= n_cur; top_q <= n_top;
			phase_q <= n_phase; part_q <= n_part; shown_q <= n_shown;
		end
	end
endmodule

[sv/bmpw_fifo.sv]
`timescale 1ns / 1ps
module bmpw_fifo import bmpw_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

[sv/bmpw_back.sv]
`timescale 1ns / 1ps
module bmpw_back import bmpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  col_off,
	input  logic [9:0]  row_off,
	input  logic        q_empty,
	input  job_t        q_job,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [15:0] out_value,
	output logic        out_last
);
	job_t        cur_q;
	logic        busy_q;
	logic [3:0]  step_q;
	logic        ov_q, ol_q;
	logic [1:0]  ok_q;
	logic [15:0] oval_q;
	logic        load;
	step_t       nxt, fst;
	logic [1:0]  kind;
	logic [15:0] val;
	logic [10:0] r11;
	logic [8:0]  wl9, wr9;

	always_comb begin
		r11 = {1'b0, row_off} + {2'b0, cur_q.row};
		wl9 = {1'b0, col_off} + {1'b0, cur_q.left};
		wr9 = {1'b0, col_off} + {1'b0, cur_q.right};
		kind = KIND_CMD;
		val  = '0;
		unique case (step_q)
			4'd0:  val = CMD_HWIN;
			4'd1: begin kind = KIND_DATA; val = {wr9[7:0], 8'd0} | {7'd0, wl9}; end
			4'd2:  val = CMD_VEND;
			4'd3: begin kind = KIND_DATA; val = {5'd0, r11}; end
			4'd4:  val = CMD_VSTART;
			4'd5: begin kind = KIND_DATA; val = {5'd0, r11}; end
			4'd6:  val = CMD_XADDR;
			4'd7: begin kind = KIND_DATA; val = {7'd0, wl9}; end
			4'd8:  val = CMD_YADDR;
			4'd9: begin kind = KIND_DATA; val = {5'd0, r11}; end
			4'd10: val = CMD_WRAM;
			4'd11: begin kind = KIND_DATA; val = cur_q.word; end
			4'd12: kind = KIND_FINISH;
			4'd13: kind = KIND_REJECT;
			default: kind = KIND_CMD;
		endcase
		nxt   = next_step(cur_q, step_q);
		fst   = first_step(q_job);
		load  = busy_q && (!ov_q || out_ready);
		q_pop = !q_empty && (!busy_q || (load && !nxt.has));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				if (nxt.has) step_q <= nxt.step;
				else if (!q_pop) busy_q <= 1'b0;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= fst.step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_job;
		if (load) begin
			ok_q   <= kind;
			oval_q <= val;
			ol_q   <= !nxt.has;
		end
	end

	assign out_valid = ov_q;
	assign out_kind  = ok_q;
	assign out_value = oval_q;
	assign out_last  = ol_q;
endmodule

[sv/bmp24_to_lcd_window_writer_top.sv]
// Any job a taken byte makes is written to the job queue, loaded into the
// beat sequencer and registered at the output. Throughput: one byte per
// cycle while the job queue has room; results leave at one beat per cycle
// while the sink is ready. The 4-entry queue absorbs row start beat runs.
// Reset: arst_n clears parser, queue, sequencer and offsets at once.
`timescale 1ns / 1ps
`include "bmp24_to_lcd_window_writer_top_assert.svh"
module bmp24_to_lcd_window_writer_top import bmpw_pkg::*; #(
	parameter int SCREEN_WIDTH    = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT   = SCREEN_HEIGHT_DEF,
	parameter int MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // file_byte
	input  logic        s_axis_tuser,  // first_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // bus_value
	output logic [1:0]  m_axis_tuser,  // write_kind
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [9:0]  cfg_wdata
);
	logic [7:0] col_q;
	logic [9:0] row_q;
	logic       acc, push, pop, full, empty;
	job_t       fjob, qjob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COLUMN: col_q <= cfg_wdata[7:0];
				REG_ROW:    row_q <= cfg_wdata;
				default:    row_q <= row_q;
			endcase
		end
	end

	assign s_axis_tready = !full;
	assign acc = s_axis_tvalid && s_axis_tready;

	bmpw_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
	) u_front (
		.clk(clk), .arst_n(arst_n), .acc(acc), .b(s_axis_tdata),
		.first(s_axis_tuser), .push(push), .job(fjob)
	);

	bmpw_fifo #(.WIDTH($bits(job_t)), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(fjob),
		.pop(pop), .rdata(qjob), .full(full), .empty(empty)
	);

	bmpw_back u_back (
		.clk(clk), .arst_n(arst_n), .col_off(col_q), .row_off(row_q),
		.q_empty(empty), .q_job(qjob), .q_pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_kind(m_axis_tuser), .out_value(m_axis_tdata), .out_last(m_axis_tlast)
	);

	`BMPW_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full)
	`BMPW_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, !empty)
	`BMPW_ASSERT_NOW(a_end_kinds_last, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == KIND_FINISH || m_axis_tuser == KIND_REJECT),
		m_axis_tlast)
endmodule

[dv/bmp24_to_lcd_window_writer_top_test.sv]
`timescale 1ns / 1ps
module bmp24_to_lcd_window_writer_top_test;
	import bmpw_pkg::*;

	localparam int SW = SCREEN_WIDTH_DEF;
	localparam int SH = SCREEN_HEIGHT_DEF;
	localparam int MAXW = MAX_IMAGE_WIDTH_DEF;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic        last;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic        cfg_idx;
	logic [9:0]  cfg_wdata;

	bmp24_to_lcd_window_writer_top uut (.*);

	// predictor state
	logic [7:0]  col_off;
	logic [9:0]  row_off;
	logic [31:0] pos_q, pix_start, img_w, img_h, skip_rows;
	logic        hdr_ok, geo_ready, done_q;
	logic [11:0] stride, row_byte;
	logic [7:0]  win_l, win_r;
	logic [8:0]  cur_row, top_row;
	logic [1:0]  phase;
	logic [15:0] part_pix;

	beat_t expected_beats[$];
	int errors = 0;
	int beats_seen = 0;
	int bytes_sent = 0;
	int images_done = 0;
	int images_rejected = 0;
	longint cycles = 0;
	logic [7:0] file_img[$];

	task automatic report(input string what);
		errors++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	task automatic parser_clear();
		pos_q = 0; pix_start = 0; img_w = 0; img_h = 0; hdr_ok = 1;
		stride = 0; skip_rows = 0; win_l = 0; win_r = 0; cur_row = 0;
		top_row = 0; row_byte = 0; phase = 0; part_pix = 0; done_q = 0;
		geo_ready = 0;
	endtask

	function automatic void push_beat(input logic [1:0] k, input logic [31:0] v);
		beat_t b;
		b.kind = k;
		b.value = v[15:0];
		b.last = 1'b0;
		expected_beats.push_back(b);
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic first);
		logic [31:0] p, xs, ys, r, c, shown;
		int n0;
		beat_t tb;
		n0 = expected_beats.size();
		if (first) parser_clear();
		p = pos_q;
		if (pos_q != 32'hFFFF_FFFF) pos_q++;
		if (p <= 33) begin
			if (p >= 10 && p <= 13) pix_start |= 32'(b) << ((p - 10) * 8);
			else if (p >= 18 && p <= 21) img_w |= 32'(b) << ((p - 18) * 8);
			else if (p >= 22 && p <= 25) img_h |= 32'(b) << ((p - 22) * 8);
			else if (p == 26) hdr_ok &= (b == 1);
			else if (p == 28) hdr_ok &= (b == 24);
			else if (p == 27 || p >= 29) hdr_ok &= (b == 0);
			if (p == 33) begin
				if (img_w == 0 || img_w > MAXW || img_h == 0 || pix_start < 34)
					hdr_ok = 0;
				if (!hdr_ok) begin
					push_beat(KIND_REJECT, 0);
					images_rejected++;
				end else begin
					stride = 12'((img_w * 3 + 3) & ~32'd3);
					if (img_w > SW) begin xs = 0; win_r = 8'(SW - 1); end
					else begin xs = (SW - img_w) / 2; win_r = 8'(xs + img_w - 1); end
					if (img_h > SH) begin
						ys = 0; cur_row = 9'(SH - 1); skip_rows = img_h - 32'(SH);
					end else begin
						ys = (SH - img_h) / 2; cur_row = 9'(ys + img_h - 1); skip_rows = 0;
					end
					win_l = xs[7:0];
					top_row = ys[8:0];
					row_byte = 0;
					phase = 0;
					geo_ready = 1;
				end
			end
		end else if (geo_ready && hdr_ok && !done_q && p >= pix_start) begin
			shown = (img_w > SW) ? SW : img_w;
			if (skip_rows == 0) begin
				if (row_byte == 0) begin
					c = col_off;
					r = row_off + cur_row;
					push_beat(KIND_CMD, CMD_HWIN);
					push_beat(KIND_DATA, ((c + win_r) << 8) | (c + win_l));
					push_beat(KIND_CMD, CMD_VEND);
					push_beat(KIND_DATA, r);
					push_beat(KIND_CMD, CMD_VSTART);
					push_beat(KIND_DATA, r);
					push_beat(KIND_CMD, CMD_XADDR);
					push_beat(KIND_DATA, c + win_l);
					push_beat(KIND_CMD, CMD_YADDR);
					push_beat(KIND_DATA, r);
					push_beat(KIND_CMD, CMD_WRAM);
				end
				if (phase == 0) begin
					part_pix = 16'(b >> 3); phase = 1;
				end else if (phase == 1) begin
					part_pix |= 16'(b >> 2) << 5; phase = 2;
				end else begin
					phase = 0;
					if (row_byte < shown * 3) begin
						push_beat(KIND_DATA, part_pix | (16'(b >> 3) << 11));
						if (row_byte == shown * 3 - 1 && cur_row == top_row) begin
							push_beat(KIND_FINISH, 0);
							done_q = 1;
							images_done++;
						end
					end
				end
			end
			if (!done_q) begin
				row_byte++;
				if (row_byte >= stride) begin
					row_byte = 0;
					phase = 0;
					if (skip_rows > 0) skip_rows--;
					else if (cur_row > top_row) cur_row--;
				end
			end
		end
		if (expected_beats.size() > n0) begin
			tb = expected_beats.pop_back();
			tb.last = 1'b1;
			expected_beats.push_back(tb);
		end
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// output side: check each beat, then stall at random
	int stall_left = 0;
	always @(posedge clk) begin
		beat_t e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				beats_seen++;
				if (expected_beats.size() == 0)
					report($sformatf("unexpected beat kind %0d value %h",
						m_axis_tuser, m_axis_tdata));
				else begin
					e = expected_beats.pop_front();
					if (m_axis_tuser !== e.kind)
						report($sformatf("kind %0d, want %0d", m_axis_tuser, e.kind));
					if (m_axis_tdata !== e.value)
						report($sformatf("value %h, want %h", m_axis_tdata, e.value));
					if (m_axis_tlast !== e.last)
						report($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
				end
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	int gap_max = 10;

	task automatic send_byte(input logic [7:0] b, input logic first);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= first;
		do @(posedge clk); while (!s_axis_tready);
		predict_byte(b, first);
		bytes_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_COLUMN) col_off = v[7:0];
		else row_off = v;
		@(posedge clk);
	endtask

	function automatic void put32(inout logic [7:0] hd[34], input int at,
			input logic [31:0] v);
		for (int i = 0; i < 4; i++) hd[at + i] = v[8*i +: 8];
	endfunction

	// build a file: header, filler up to the offset, then pixel bytes
	task automatic build_file(input logic [31:0] off, input logic [31:0] w,
			input logic [31:0] h, input logic [7:0] planes, input logic [7:0] bpp,
			input logic [7:0] comp, input int pix_bytes);
		logic [7:0] hd[34];
		for (int i = 0; i < 34; i++) hd[i] = 8'($urandom_range(0, 255));
		for (int i = 26; i < 34; i++) hd[i] = 0;
		put32(hd, 10, off);
		put32(hd, 18, w);
		put32(hd, 22, h);
		hd[26] = planes;
		hd[28] = bpp;
		hd[30] = comp;
		file_img.delete();
		for (int i = 0; i < 34; i++) file_img.push_back(hd[i]);
		for (int i = 34; i < off; i++) file_img.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < pix_bytes; i++) file_img.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_file(input logic mark_first);
		foreach (file_img[i]) send_byte(file_img[i], (i == 0) ? mark_first : 1'b0);
	endtask

	task automatic test_reset_state();
		build_file(34, 1, 1, 1, 24, 0, 4);
		send_file(1'b0);
		drain();
	endtask

	task automatic test_bad_headers();
		build_file(34, 0, 2, 1, 24, 0, 0); send_file(1); drain();
		build_file(34, MAXW + 1, 2, 1, 24, 0, 0); send_file(1); drain();
		build_file(34, 2, 0, 1, 24, 0, 0); send_file(1); drain();
		build_file(33, 2, 2, 1, 24, 0, 0); send_file(1); drain();
		build_file(34, 2, 2, 2, 24, 0, 0); send_file(1); drain();
		build_file(34, 2, 2, 1, 32, 0, 0); send_file(1); drain();
		build_file(34, 2, 2, 1, 24, 1, 0); send_file(1); drain();
	endtask

	task automatic test_extremes();
		write_reg(REG_COLUMN, 10'd255);
		write_reg(REG_ROW, 10'd1023);
		build_file(40, 3, 2, 1, 24, 0, 24); send_file(1); drain();
		write_reg(REG_COLUMN, 10'd0);
		write_reg(REG_ROW, 10'd0);
		// wide image: crop the window
		build_file(34, 245, 1, 1, 24, 0, 24); send_file(1); drain();
		// tall image: skip bottom rows
		build_file(34, 1, 322, 1, 24, 0, 16); send_file(1); drain();
		// negative height: skips forever
		build_file(34, 1, 32'hFFFF_FFF0, 1, 24, 0, 8); send_file(1); drain();
	endtask

	task automatic test_random_files(input int target);
		int start, w, h, off, kind;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			if ($urandom_range(0, 1)) write_reg(REG_COLUMN, 10'($urandom_range(0, 255)));
			if ($urandom_range(0, 1)) write_reg(REG_ROW, 10'($urandom_range(0, 1023)));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			kind = $urandom_range(0, 9);
			w = $urandom_range(1, 4);
			h = $urandom_range(1, 3);
			off = $urandom_range(34, 40);
			if (kind == 0)
				build_file(off, $urandom, $urandom, 8'($urandom), 8'($urandom),
					8'($urandom), 10);
			else if (kind == 1)
				build_file(off, w, h, 1, 24, 0, $urandom_range(0, 20));
			else
				build_file(off, w, h, 1, 24, 0, ((w * 3 + 3) & ~3) * h + $urandom_range(0, 6));
			send_file($urandom_range(0, 7) != 0);
			if ($urandom_range(0, 3) == 0)
				for (int i = 0; i < 5; i++) send_byte(8'($urandom), 1'b0);
			drain();
		end
		gap_max = 10;
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_idx = 0;
		cfg_wdata = 0;
		col_off = 0;
		row_off = 0;
		parser_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_bad_headers();
		test_extremes();
		test_random_files(80);
		drain();
		$display("sent %0d file bytes, checked %0d beats", bytes_sent, beats_seen);
		$display("images drawn %0d, rejected %0d", images_done, images_rejected);
		if (errors == 0 && expected_beats.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
